// File: design/spwm_pkg.sv
// Package for the five-channel servo pulse generator.
// Holds the shared types, command and register codes, and reset tables.
// No dependencies.
`timescale 1ns / 1ps

package spwm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int PULSE_W      = 5;
  localparam int SLOW_FIRST   = 3;   // zero-based index of the first slow channel

  // request modes
  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_POSITION = 2'd1;
  localparam logic [1:0] MODE_ENABLE   = 2'd2;

  // configuration register indexes
  localparam logic REG_FRAME_TOP  = 1'b0;
  localparam logic REG_LED_FRAMES = 1'b1;

  localparam logic [11:0] FRAME_TOP_RESET  = 12'd2500;
  localparam logic [7:0]  LED_FRAMES_RESET = 8'd30;

  localparam logic [7:0] PCT_MAX  = 8'd100;
  localparam logic [7:0] BAND_LO  = 8'd48;
  localparam logic [7:0] BAND_HI  = 8'd52;
  localparam logic [7:0] CH1_SKIP = 8'd60;
  localparam logic [7:0] CH2_SKIP = 8'd41;
  localparam logic [7:0] CH1_OFS  = 8'd136;
  localparam logic [7:0] CH2_OFS  = 8'd137;
  localparam logic [7:0] CH3_OFS  = 8'd119;
  localparam logic [7:0] CH4_OFS  = 8'd60;

  typedef struct packed {
    logic        valid;
    logic        index;
    logic [11:0] data;
  } spwm_cfg_t;

  typedef struct packed {
    logic       tick_en;
    logic       set_en;
    logic       enable_en;
    logic [2:0] chan_idx;   // zero-based
    logic [7:0] value;
  } spwm_op_t;

  typedef struct packed {
    logic       start;
    logic [7:0] fast_next;
    logic [7:0] slow_next;
  } spwm_timing_t;

  typedef struct packed {
    logic       cmp_write;
    logic       en_write;
    logic [7:0] cmp;
    logic       en;
  } pos_upd_t;

  function automatic logic [7:0] compare_reset(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd186;
      3'd1:    r = 8'd187;
      3'd2:    r = 8'd169;
      3'd3:    r = 8'd60;
      3'd4:    r = 8'd85;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic enable_reset(input logic [2:0] idx);
    return (idx == 3'd3) || (idx == 3'd4);
  endfunction

  function automatic logic out_of_band(input logic [7:0] p);
    return !((p >= BAND_LO) && (p <= BAND_HI));
  endfunction

  // percent to compare value per channel, and enable for the first three
  function automatic pos_upd_t position_update(input logic [2:0] idx,
                                               input logic [7:0] value);
    pos_upd_t   u;
    logic [7:0] p;
    p = (value > PCT_MAX) ? PCT_MAX : value;
    u = '0;
    case (idx)
      3'd0: begin
        if (p == CH1_SKIP) p = CH1_SKIP + 8'd1;
        u.cmp_write = 1'b1;
        u.en_write  = 1'b1;
        u.cmp       = CH1_OFS + p;
        u.en        = out_of_band(p);
      end
      3'd1: begin
        if (p == CH2_SKIP) p = CH2_SKIP + 8'd1;
        p           = PCT_MAX - p;   // channel 2 runs inverted
        u.cmp_write = 1'b1;
        u.en_write  = 1'b1;
        u.cmp       = CH2_OFS + p;
        u.en        = out_of_band(p);
      end
      3'd2: begin
        u.cmp_write = 1'b1;
        u.en_write  = 1'b1;
        u.cmp       = CH3_OFS + p;
        u.en        = out_of_band(p);
      end
      3'd3: begin
        u.cmp_write = 1'b1;
        u.cmp       = CH4_OFS + p;
      end
      3'd4: begin
        u.cmp_write = 1'b1;
        u.cmp       = p;
      end
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

// File: design/spwm_frame.sv
// Frame timing for the servo pulse generator: frame counter, fast and slow
// channel counters, heartbeat LED and the two configuration registers.
// Depends on spwm_pkg.
`timescale 1ns / 1ps

module spwm_frame (
  input  logic                  clk,
  input  logic                  rst,
  input  spwm_pkg::spwm_cfg_t   cfg,
  input  logic                  tick_en,
  output spwm_pkg::spwm_timing_t timing,
  output logic                  led_next
);
  import spwm_pkg::*;

  logic [11:0] frame_top;
  logic [7:0]  led_frames;
  logic [11:0] frame_count;
  logic [7:0]  fast_count;
  logic [7:0]  slow_count;
  logic        slow_prescale;
  logic        led_state;
  logic [7:0]  frame_tally;

  logic [11:0] frame_inc;
  logic        led_toggle;

  assign frame_inc        = frame_count + 12'd1;
  assign timing.start     = (frame_inc == frame_top);
  assign timing.fast_next = fast_count + 8'd1;
  // slow counter steps when the prescaler wraps back to zero
  assign timing.slow_next = slow_prescale ? (slow_count + 8'd1) : slow_count;
  assign led_toggle       = tick_en && timing.start && (frame_tally == led_frames);
  assign led_next         = led_state ^ led_toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_top  <= FRAME_TOP_RESET;
      led_frames <= LED_FRAMES_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_TOP:  frame_top  <= cfg.data;
        REG_LED_FRAMES: led_frames <= cfg.data[7:0];
        default:        frame_top  <= frame_top;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count   <= '0;
      fast_count    <= '0;
      slow_count    <= '0;
      slow_prescale <= 1'b0;
      led_state     <= 1'b0;
      frame_tally   <= '0;
    end else if (tick_en) begin
      if (timing.start) begin
        frame_count   <= '0;
        fast_count    <= '0;
        slow_count    <= '0;
        slow_prescale <= 1'b0;
        led_state     <= led_next;
        frame_tally   <= led_toggle ? 8'd0 : (frame_tally + 8'd1);
      end else begin
        frame_count   <= frame_inc;
        fast_count    <= timing.fast_next;
        slow_count    <= timing.slow_next;
        slow_prescale <= ~slow_prescale;
      end
    end
  end

endmodule

// File: design/spwm_chan.sv
// Per-channel compare values, enables and pin levels.
// Depends on spwm_pkg; counter values come from spwm_frame.
`timescale 1ns / 1ps

module spwm_chan #(
  parameter int NUM_CHANNELS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  spwm_pkg::spwm_op_t     op,
  input  spwm_pkg::spwm_timing_t timing,
  output logic [NUM_CHANNELS-1:0] pins_next
);
  import spwm_pkg::*;

  logic [7:0]              cmp      [NUM_CHANNELS];
  logic [7:0]              cmp_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] en;
  logic [NUM_CHANNELS-1:0] en_next;
  logic [NUM_CHANNELS-1:0] pins;
  pos_upd_t                upd;

  assign upd = position_update(op.chan_idx, op.value);

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      logic       sel;
      logic [7:0] cnt;
      sel         = (op.chan_idx == 3'(i));
      cnt         = (i >= SLOW_FIRST) ? timing.slow_next : timing.fast_next;
      cmp_next[i] = cmp[i];
      en_next[i]  = en[i];
      pins_next[i] = pins[i];
      if (op.tick_en) begin
        if (timing.start) pins_next[i] = 1'b1;
        else if (en[i] && (cnt == cmp[i])) pins_next[i] = 1'b0;
      end
      if (op.set_en && sel) begin
        if (upd.cmp_write) cmp_next[i] = upd.cmp;
        if (upd.en_write)  en_next[i]  = upd.en;
      end
      if (op.enable_en && sel) en_next[i] = (op.value != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cmp[i] <= compare_reset(3'(i));
        en[i]  <= enable_reset(3'(i));
      end
      pins <= '0;
    end else begin
      cmp  <= cmp_next;
      en   <= en_next;
      pins <= pins_next;
    end
  end

endmodule

// File: design/five_channel_servo_pwm.sv
// Five-channel servo pulse generator. Each tick request advances the frame
// counter and the channel counters; position and enable requests update one
// channel. One request is taken every clock cycle unless a stalled result
// holds it back; its result passes the input and result registers that
// bracket the single pass of logic. The result register can hold a
// stalled result while the next request is taken. Configuration writes are
// taken at any time (cfg_ready is always high) and should be made while idle.
// Depends on spwm_pkg, spwm_frame and spwm_chan.
`timescale 1ns / 1ps

module five_channel_servo_pwm #(
  parameter int NUM_CHANNELS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [2:0]  channel,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  pulse_levels,
  output logic        led_level,
  output logic        frame_start,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import spwm_pkg::*;

  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [2:0]  s1_channel;
  logic [7:0]  s1_value;
  logic        advance;
  logic        chan_ok;

  spwm_cfg_t               cfg;
  spwm_op_t                op;
  spwm_timing_t            timing;
  logic                    led_next;
  logic [NUM_CHANNELS-1:0] pins_next;
  logic [MAX_CHANNELS-1:0] pins_wide;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign chan_ok = (s1_channel != 3'd0) && ({1'b0, s1_channel} <= 4'(NUM_CHANNELS));

  assign op.tick_en   = advance && (s1_mode == MODE_TICK);
  assign op.set_en    = advance && (s1_mode == MODE_POSITION) && chan_ok;
  assign op.enable_en = advance && (s1_mode == MODE_ENABLE) && chan_ok;
  assign op.chan_idx  = s1_channel - 3'd1;
  assign op.value     = s1_value;

  spwm_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .tick_en  (op.tick_en),
    .timing   (timing),
    .led_next (led_next)
  );

  spwm_chan #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_chan (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .timing    (timing),
    .pins_next (pins_next)
  );

  assign pins_wide = MAX_CHANNELS'(pins_next);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode    <= mode;
      s1_channel <= channel;
      s1_value   <= value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_levels <= pins_wide[PULSE_W-1:0];
      led_level    <= led_next;
      frame_start  <= op.tick_en && timing.start;
    end
  end

endmodule

// File: design/spwm_checker.sv
// Port-level checks for the servo pulse generator, bound to the top level.
// Depends on five_channel_servo_pwm ports only.
`timescale 1ns / 1ps

module spwm_checker #(
  parameter int NUM_CHANNELS = 5
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] pulse_levels,
  input logic       led_level,
  input logic       frame_start
);
  localparam logic [4:0] PIN_MASK = 5'((9'd1 << NUM_CHANNELS) - 9'd1);

  // a new frame drives every pin high
  a_frame_all_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_start |-> pulse_levels == PIN_MASK)
    else $error("frame start without all pins high");

  // pins beyond the channel count never show
  a_unused_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_levels & ~PIN_MASK) == 5'd0)
    else $error("unused pin driven");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pulse_levels)
      && $stable(led_level) && $stable(frame_start))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind five_channel_servo_pwm spwm_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_spwm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .pulse_levels (pulse_levels),
  .led_level    (led_level),
  .frame_start  (frame_start)
);
